// ===== hdl/wss_pkg.sv =====
// Shared types and constants for the weekly setpoint schedule table.
// No dependencies; the interfaces and the table module use this package.
package wss_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	localparam int DAY_W    = 4;
	localparam int MINUTE_W = 11;
	localparam int TEMP_W   = 12;
	localparam int ROW_W    = 5;
	localparam int COUNT_W  = 6;
	localparam int KEY_W    = DAY_W + MINUTE_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = TEMP_W;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [DAY_W-1:0]         day_t;
	typedef logic [MINUTE_W-1:0]      minute_t;

	localparam temp_t DEFAULT_LOW_RST  = 12'sd1040;
	localparam temp_t DEFAULT_HIGH_RST = 12'sd1200;

	// last day code that names a single day (Saturday)
	localparam day_t LAST_SINGLE_DAY = 4'd6;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_LOOKUP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_ROW_RANGE = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEFAULT_LOW  = 1'b0,
		CFG_DEFAULT_HIGH = 1'b1
	} cfg_index_t;

	typedef struct packed {
		day_t    day;
		minute_t minute;
		temp_t   lo;
		temp_t   hi;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/wss_cmd_if.sv =====
// Command channel of the schedule table: valid/ready plus one operation.
// Depends on wss_pkg for field types.
interface wss_cmd_if;
	logic                        valid;
	logic                        ready;
	wss_pkg::kind_t              kind;
	wss_pkg::day_t               day_code;
	wss_pkg::minute_t            minute_of_day;
	wss_pkg::temp_t              low_setpoint;
	wss_pkg::temp_t              high_setpoint;
	logic [wss_pkg::ROW_W-1:0]   row_index;

	modport source (
		output valid, kind, day_code, minute_of_day, low_setpoint, high_setpoint,
		       row_index,
		input  ready
	);
	modport sink (
		input  valid, kind, day_code, minute_of_day, low_setpoint, high_setpoint,
		       row_index,
		output ready
	);
endinterface

// ===== hdl/wss_rsp_if.sv =====
// Result channel of the schedule table: valid/ready plus one result.
// Depends on wss_pkg for field types.
interface wss_rsp_if;
	logic                        valid;
	logic                        ready;
	wss_pkg::temp_t              current_low;
	wss_pkg::temp_t              current_high;
	logic                        found;
	logic [wss_pkg::COUNT_W-1:0] entry_count;
	wss_pkg::status_t            status;

	modport source (
		output valid, current_low, current_high, found, entry_count, status,
		input  ready
	);
	modport sink (
		input  valid, current_low, current_high, found, entry_count, status,
		output ready
	);
endinterface

// ===== hdl/wss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/weekly_setpoint_schedule_table.sv =====
// Weekly setpoint schedule table, sorted by {day, minute}, held in one RAM.
// Insert scans for its position, shifts later entries up and writes (an equal key is overwritten);
// delete shifts later entries down; lookup scans; clear and out-of-range delete go straight to the result.
// One operation in flight; the next is taken once the result is registered.
// Throughput is set by the single RAM read port walking the table.
// Reset: table empty, defaults 1040/1200 in force; no clearing pass needed.
module weekly_setpoint_schedule_table #(
	parameter int TABLE_DEPTH = wss_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wss_pkg::CFG_DATA_W-1:0]   cfg_data,
	wss_cmd_if.sink                          cmd,
	wss_rsp_if.source                        rsp
);
	import wss_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_SHIFT_UP = 6'b000100,
		ST_SHIFT_DN = 6'b001000,
		ST_WRITE    = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

	state_t           state_q;
	kind_t            kind_q;
	day_t             day_q;
	minute_t          minute_q;
	temp_t            lo_q;
	temp_t            hi_q;

	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] pos_q;
	logic             pos_fnd_q;
	logic             eq_q;
	logic             hit_q;
	temp_t            cand_lo_q;
	temp_t            cand_hi_q;
	status_t          status_q;

	temp_t            held_low_q;
	temp_t            held_high_q;
	logic             adopted_q;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic               out_vld_q;
	temp_t              out_low_q;
	temp_t              out_high_q;
	logic               out_found_q;
	logic [COUNT_W-1:0] out_count_q;
	status_t            out_status_q;

	logic               rd_en;
	logic [IDX_W-1:0]   raddr;
	logic               mem_we;
	logic [IDX_W-1:0]   waddr;
	entry_t             wdata;
	logic [ENTRY_W-1:0] rdata;
	entry_t             rd_entry;
	entry_t             new_entry;

	logic               accept;
	logic               scan_done;
	logic               shift_done;
	logic               out_load;
	logic [KEY_W-1:0]   rd_key;
	logic [KEY_W-1:0]   new_key;
	logic [CMP_W-1:0]   row_ext;
	logic [CMP_W-1:0]   used_ext;
	logic [CNT_W-1:0]   ins_pos;

	assign accept     = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == ST_IDLE);
	assign rd_entry   = entry_t'(rdata);
	assign new_entry  = '{day: day_q, minute: minute_q, lo: lo_q, hi: hi_q};
	assign rd_key     = {rd_entry.day, rd_entry.minute};
	assign new_key    = {day_q, minute_q};
	assign scan_done  = (ptr_q == used_q) && !vld_s1;
	assign shift_done = (rem_q == '0) && !vld_s1;
	assign out_load   = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);
	assign row_ext    = CMP_W'(cmd.row_index);
	assign used_ext   = CMP_W'(used_q);
	assign ins_pos    = pos_fnd_q ? pos_q : used_q;

	// RAM port steering
	always_comb begin
		rd_en  = 1'b0;
		raddr  = ptr_q[IDX_W-1:0];
		mem_we = 1'b0;
		waddr  = pos_q[IDX_W-1:0];
		wdata  = new_entry;
		case (state_q)
			ST_SCAN: begin
				rd_en = (ptr_q != used_q);
			end
			ST_SHIFT_UP: begin
				rd_en  = (rem_q != '0);
				mem_we = vld_s1;
				waddr  = idx_s1 + IDX_W'(1);
				wdata  = rd_entry;
			end
			ST_SHIFT_DN: begin
				rd_en  = (rem_q != '0);
				mem_we = vld_s1;
				waddr  = idx_s1 - IDX_W'(1);
				wdata  = rd_entry;
			end
			ST_WRITE: begin
				mem_we = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	wss_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			pos_fnd_q   <= 1'b0;
			eq_q        <= 1'b0;
			hit_q       <= 1'b0;
			cand_lo_q   <= '0;
			cand_hi_q   <= '0;
			status_q    <= STATUS_OK;
			held_low_q  <= DEFAULT_LOW_RST;
			held_high_q <= DEFAULT_HIGH_RST;
			adopted_q   <= 1'b0;
			vld_s1      <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			vld_s1 <= rd_en;

			// defaults stay in force until a lookup adopts an entry
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_DEFAULT_LOW: begin
						if (!adopted_q) begin
							held_low_q <= temp_t'(cfg_data);
						end
					end
					CFG_DEFAULT_HIGH: begin
						if (!adopted_q) begin
							held_high_q <= temp_t'(cfg_data);
						end
					end
					default: ;
				endcase
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q  <= STATUS_OK;
						hit_q     <= 1'b0;
						pos_fnd_q <= 1'b0;
						eq_q      <= 1'b0;
						ptr_q     <= '0;
						case (cmd.kind)
							KIND_INSERT, KIND_LOOKUP: begin
								state_q <= ST_SCAN;
							end
							KIND_DELETE: begin
								if (row_ext >= used_ext) begin
									status_q <= STATUS_ROW_RANGE;
									state_q  <= ST_DONE;
								end else begin
									ptr_q   <= CNT_W'(row_ext + CMP_W'(1));
									rem_q   <= CNT_W'(used_ext - row_ext - CMP_W'(1));
									used_q  <= used_q - CNT_W'(1);
									state_q <= ST_SHIFT_DN;
								end
							end
							KIND_CLEAR: begin
								used_q  <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (vld_s1) begin
						if (kind_q == KIND_LOOKUP) begin
							// keep the last match in table order
							if (day_q <= LAST_SINGLE_DAY && rd_entry.day == day_q &&
							    rd_entry.minute <= minute_q) begin
								hit_q     <= 1'b1;
								cand_lo_q <= rd_entry.lo;
								cand_hi_q <= rd_entry.hi;
							end
						end else if (!pos_fnd_q && rd_key >= new_key) begin
							pos_fnd_q <= 1'b1;
							pos_q     <= CNT_W'(idx_s1);
							eq_q      <= (rd_key == new_key);
						end
					end
					if (scan_done) begin
						if (kind_q == KIND_LOOKUP) begin
							if (hit_q) begin
								held_low_q  <= cand_lo_q;
								held_high_q <= cand_hi_q;
								adopted_q   <= 1'b1;
							end
							state_q <= ST_DONE;
						end else if (pos_fnd_q && eq_q) begin
							state_q <= ST_WRITE;
						end else if (used_q == FULL_COUNT) begin
							status_q <= STATUS_FULL;
							state_q  <= ST_DONE;
						end else begin
							pos_q   <= ins_pos;
							rem_q   <= used_q - ins_pos;
							ptr_q   <= used_q - CNT_W'(1);
							state_q <= ST_SHIFT_UP;
						end
					end
				end
				ST_SHIFT_UP: begin
					if (rd_en) begin
						ptr_q <= ptr_q - CNT_W'(1);
						rem_q <= rem_q - CNT_W'(1);
					end
					if (shift_done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_SHIFT_DN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + CNT_W'(1);
						rem_q <= rem_q - CNT_W'(1);
					end
					if (shift_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_WRITE: begin
					if (!eq_q) begin
						used_q <= used_q + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= cmd.kind;
			day_q    <= cmd.day_code;
			minute_q <= cmd.minute_of_day;
			lo_q     <= cmd.low_setpoint;
			hi_q     <= cmd.high_setpoint;
		end
		if (rd_en) begin
			idx_s1 <= raddr;
		end
		if (out_load) begin
			out_low_q    <= held_low_q;
			out_high_q   <= held_high_q;
			out_found_q  <= hit_q;
			out_count_q  <= COUNT_W'(used_q);
			out_status_q <= status_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.current_low  = out_low_q;
	assign rsp.current_high = out_high_q;
	assign rsp.found        = out_found_q;
	assign rsp.entry_count  = out_count_q;
	assign rsp.status       = out_status_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_COUNT)
		else $error("entry count above table depth");

	a_no_rw_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && rd_en) |-> (waddr != raddr))
		else $error("shift reads and writes the same row");

	a_adopted_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		adopted_q |=> adopted_q)
		else $error("adopted flag dropped");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && status_q == STATUS_FULL) |-> (used_q == FULL_COUNT))
		else $error("insert dropped with room left");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !mem_we)
		else $error("table written outside an operation");
endmodule
